### sv/mfid_pkg.sv
package mfid_pkg;

  localparam int DEF_MAX_BYTES = 6;
  localparam int RAW_W = 48;
  localparam int INT_W = 49;
  localparam int EXP_W = 13;
  localparam int SIG_W = 14;
  localparam int FRAC_W = 13;
  localparam int EFIELD_W = 12;
  localparam int BIAS_W = 11;
  localparam int SIZE_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 3;
  localparam int WIDE_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_LITTLE_ENDIAN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_KIND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_BYTES = 2'd2;

  typedef enum logic [1:0] {
    KIND_UNSIGNED = 2'd0,
    KIND_SIGNED = 2'd1,
    KIND_FLOAT = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e_t;

  // Decoded fields handed from the field stage to the output stage.
  typedef struct packed {
    kind_e_t kind;
    logic [INT_W-1:0] ival;
    logic sign;
    logic [EFIELD_W-1:0] efield;
    logic [FRAC_W-1:0] frac;
    logic [BIAS_W-1:0] bias;
    logic err;
  } mfid_dec_t;

endpackage

### sv/mfid_align.sv
module mfid_align import mfid_pkg::*; #(
  parameter int MAX_BYTES = DEF_MAX_BYTES
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [RAW_W-1:0] raw_word,
  input  logic little_endian,
  input  kind_e_t data_kind,
  input  logic [CFG_DATA_W-1:0] size_bytes,
  output logic valid,
  output logic [MAX_BYTES*8-1:0] word,
  output kind_e_t kind,
  output logic [SIZE_W-1:0] size
);

  localparam logic [SIZE_W-1:0] MaxSize = SIZE_W'(MAX_BYTES);

  logic [SIZE_W-1:0] size_next;
  logic [MAX_BYTES*8-1:0] word_next;

  always_comb begin
    logic [WIDE_W-1:0] raw_wide;
    logic [7:0] bytes_in [MAX_BYTES];
    logic [7:0] bytes_rev [MAX_BYTES];
    raw_wide = WIDE_W'(raw_word);
    size_next = SIZE_W'(size_bytes);
    if (size_next == '0) begin
      size_next = SIZE_W'(1);
    end
    if (size_next > MaxSize) begin
      size_next = MaxSize;
    end
    // Bytes above the word size read as zero.
    for (int j = 0; j < MAX_BYTES; j++) begin
      bytes_in[j] = (j < int'(size_next)) ? raw_wide[8*j +: 8] : 8'h00;
    end
    // Byte j of the reversed word is byte size-1-j of the original.
    for (int j = 0; j < MAX_BYTES; j++) begin
      bytes_rev[j] = 8'h00;
      for (int i = 0; i < MAX_BYTES; i++) begin
        if (i + j + 1 == int'(size_next)) begin
          bytes_rev[j] = bytes_in[i];
        end
      end
    end
    for (int j = 0; j < MAX_BYTES; j++) begin
      word_next[8*j +: 8] = little_endian ? bytes_rev[j] : bytes_in[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      word <= word_next;
      kind <= data_kind;
      size <= size_next;
    end
  end

endmodule

### sv/mfid_field.sv
module mfid_field import mfid_pkg::*; #(
  parameter int MAX_BYTES = DEF_MAX_BYTES
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [MAX_BYTES*8-1:0] word,
  input  kind_e_t kind,
  input  logic [SIZE_W-1:0] size,
  output logic valid,
  output mfid_dec_t dec
);

  mfid_dec_t dec_next;

  always_comb begin
    logic [WIDE_W-1:0] w;
    logic [WIDE_W-1:0] keep;
    logic [WIDE_W-1:0] ival;
    logic top_bit;
    w = WIDE_W'(word);
    top_bit = 1'b0;
    keep = '0;
    for (int s = 1; s <= 8; s++) begin
      if (int'(size) == s) begin
        top_bit = w[8*s-1];
      end
    end
    for (int j = 0; j < 8; j++) begin
      if (j < int'(size)) begin
        keep[8*j +: 8] = 8'hFF;
      end
    end
    ival = w;
    if (kind == KIND_SIGNED && top_bit) begin
      ival = w | ~keep;
    end

    dec_next.kind = kind;
    dec_next.ival = (kind == KIND_UNSIGNED || kind == KIND_SIGNED) ? ival[INT_W-1:0] : '0;
    dec_next.sign = top_bit;
    dec_next.err = 1'b0;
    dec_next.efield = '0;
    dec_next.frac = '0;
    dec_next.bias = '0;
    // Fixed split of sign, exponent and fraction for each float size with a format; other sizes flag an error.
    unique case (size)
      SIZE_W'(1): begin
        dec_next.efield = EFIELD_W'(w[6:3]);
        dec_next.frac = {w[2:0], 10'b0};
        dec_next.bias = BIAS_W'(7);
      end
      SIZE_W'(2): begin
        dec_next.efield = EFIELD_W'(w[14:9]);
        dec_next.frac = {w[8:0], 4'b0};
        dec_next.bias = BIAS_W'(31);
      end
      SIZE_W'(3): begin
        dec_next.efield = EFIELD_W'(w[22:15]);
        dec_next.frac = w[14:2];
        dec_next.bias = BIAS_W'(127);
      end
      SIZE_W'(4): begin
        dec_next.efield = EFIELD_W'(w[30:21]);
        dec_next.frac = w[20:8];
        dec_next.bias = BIAS_W'(511);
      end
      SIZE_W'(6): begin
        dec_next.efield = w[46:35];
        dec_next.frac = w[34:22];
        dec_next.bias = BIAS_W'(2047);
      end
      default: begin
        dec_next.err = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      dec <= dec_next;
    end
  end

endmodule

### sv/mfid_out.sv
module mfid_out import mfid_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  mfid_dec_t dec,
  output logic valid,
  output logic signed [INT_W-1:0] int_value,
  output logic float_sign,
  output logic signed [EXP_W-1:0] float_exponent,
  output logic [SIG_W-1:0] float_significand,
  output logic status
);

  logic is_float;
  logic [EXP_W-1:0] exp_next;
  logic [SIG_W-1:0] sig_next;

  assign is_float = (dec.kind == KIND_FLOAT) && !dec.err;

  always_comb begin
    if (dec.efield == '0) begin
      // Denormal: fixed exponent of one minus the bias, no hidden one.
      exp_next = EXP_W'(1) - EXP_W'(dec.bias);
      sig_next = {1'b0, dec.frac};
    end else begin
      exp_next = EXP_W'(dec.efield) - EXP_W'(dec.bias);
      sig_next = {1'b1, dec.frac};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      int_value <= dec.ival;
      float_sign <= is_float ? dec.sign : 1'b0;
      float_exponent <= is_float ? exp_next : '0;
      float_significand <= is_float ? sig_next : '0;
      status <= (dec.kind == KIND_FLOAT) && dec.err;
    end
  end

endmodule

### sv/minifloat_and_integer_decoder_core.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     raw_word
// out       output     out_valid / out_ready   int_value, float_sign, float_exponent,
//                                              float_significand, status
// cfg       input      cfg_we (no wait)        cfg_idx, cfg_data
//
// Three register stages (byte alignment, field split, output register) carry each
// item in turn, and a new item can enter in every cycle while in_ready is high.
// Reset clears the stage valid bits and loads little-endian off, unsigned kind
// and a one-byte word. A stall at the output holds only full stages, so in_ready
// drops only when all three stages are full and the output is stalled.
module minifloat_and_integer_decoder_core import mfid_pkg::*; #(
  parameter int MAX_BYTES = DEF_MAX_BYTES
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [RAW_W-1:0] raw_word,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [INT_W-1:0] int_value,
  output logic float_sign,
  output logic signed [EXP_W-1:0] float_exponent,
  output logic [SIG_W-1:0] float_significand,
  output logic status,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers. The user must change them only with the pipeline empty; the block does not enforce it.
  logic little_endian;
  kind_e_t data_kind;
  logic [CFG_DATA_W-1:0] size_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      little_endian <= 1'b0;
      data_kind <= KIND_UNSIGNED;
      size_bytes <= CFG_DATA_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LITTLE_ENDIAN: little_endian <= cfg_data[0];
        REG_DATA_KIND: data_kind <= kind_e_t'(cfg_data[1:0]);
        REG_SIZE_BYTES: size_bytes <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Stage enables. A stage loads when it is empty or its successor loads.
  logic en_a, en_b, en_c;
  logic v_a, v_b;
  logic [MAX_BYTES*8-1:0] word_a;
  kind_e_t kind_a;
  logic [SIZE_W-1:0] size_a;
  mfid_dec_t dec_b;

  assign en_c = !out_valid || out_ready;
  assign en_b = !v_b || en_c;
  assign en_a = !v_a || en_b;
  assign in_ready = en_a;

  // The first stage masks the word to its size and reverses the bytes if asked.
  mfid_align #(.MAX_BYTES(MAX_BYTES)) u_align (
    .clk(clk),
    .rst(rst),
    .en(en_a),
    .in_valid(in_valid),
    .raw_word(raw_word),
    .little_endian(little_endian),
    .data_kind(data_kind),
    .size_bytes(size_bytes),
    .valid(v_a),
    .word(word_a),
    .kind(kind_a),
    .size(size_a)
  );

  // The second stage sign-extends integers and splits floats into fields.
  mfid_field #(.MAX_BYTES(MAX_BYTES)) u_field (
    .clk(clk),
    .rst(rst),
    .en(en_b),
    .in_valid(v_a),
    .word(word_a),
    .kind(kind_a),
    .size(size_a),
    .valid(v_b),
    .dec(dec_b)
  );

  // The last stage removes the bias, adds the hidden one to normal floats and holds the result.
  mfid_out u_out (
    .clk(clk),
    .rst(rst),
    .en(en_c),
    .in_valid(v_b),
    .dec(dec_b),
    .valid(out_valid),
    .int_value(int_value),
    .float_sign(float_sign),
    .float_exponent(float_exponent),
    .float_significand(float_significand),
    .status(status)
  );

  // An unsupported float size leaves every other field at zero.
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> int_value == '0 && float_significand == '0 &&
      float_exponent == '0 && !float_sign)
    else $error("status set with nonzero result fields");

  // Integer and float results never appear together.
  a_kind_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && int_value != '0 |-> float_significand == '0 && !float_sign)
    else $error("integer and float fields both set");

  // The input side backs up only when every stage is full and the output stalls.
  a_full_only: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> v_a && v_b && out_valid && !out_ready)
    else $error("input stalled with room in the pipeline");

  // A hidden one at the top of the significand appears only in a float result.
  a_hidden_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && float_significand[SIG_W-1] |-> !status && int_value == '0)
    else $error("hidden one set outside a float result");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mfid_pkg::*;

  // One decoded result, laid out as the block presents it on its output channel.
  typedef struct packed {
    logic signed [INT_W-1:0] ival;
    logic                    sgn;
    logic signed [EXP_W-1:0] fexp;
    logic [SIG_W-1:0]        fsig;
    logic                    stat;
  } decoded_t;

  // A directed item carries the register setting it runs under. Where the result can be
  // read straight off the format, it is typed in; otherwise the predictor supplies it.
  typedef struct {
    logic             le;
    kind_e_t          kind;
    logic [2:0]       size;
    logic [RAW_W-1:0] word;
    logic             known;
    decoded_t         want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [RAW_W-1:0] raw_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [INT_W-1:0] int_value;
  logic float_sign;
  logic signed [EXP_W-1:0] float_exponent;
  logic [SIG_W-1:0] float_significand;
  logic status;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Our copy of the register file. It starts at the reset values of the block.
  logic       le_cfg = 1'b0;
  kind_e_t    kind_cfg = KIND_UNSIGNED;
  logic [2:0] size_cfg = 3'd1;

  // Results still owed by the block, oldest first.
  decoded_t pending_decodes[$];
  dir_row_t dir_rows[$];

  int mismatches = 0;
  // Chance, in percent, that a side idles in a given cycle.
  int send_idle_pct = 24;
  int recv_idle_pct = 24;
  // A nonzero value asks the receiver to hold off for that many cycles.
  int hold_len = 0;

  minifloat_and_integer_decoder_core u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .raw_word          (raw_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .int_value         (int_value),
    .float_sign        (float_sign),
    .float_exponent    (float_exponent),
    .float_significand (float_significand),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decodes one word under the given register setting. Sizes out of range are clamped
  // the way the block does it: zero reads as one byte, anything past the widest word
  // reads as the widest word. Float sizes without a format only raise the status bit.
  function automatic decoded_t decode_word(input logic [RAW_W-1:0] w, input logic le,
                                           input kind_e_t kind, input logic [2:0] size_reg);
    int nb;
    int nbits;
    int ebits;
    int fbits;
    int bias;
    logic [63:0] m;
    logic [63:0] v;
    logic [63:0] rev;
    logic [63:0] efield;
    logic [63:0] frac;
    logic [FRAC_W-1:0] f13;
    decoded_t d;
    d = '0;
    nb = int'(size_reg);
    if (nb == 0) nb = 1;
    if (nb > DEF_MAX_BYTES) nb = DEF_MAX_BYTES;
    nbits = nb * 8;
    m = (64'd1 << nbits) - 64'd1;
    v = {16'd0, w} & m;
    if (le) begin
      rev = '0;
      for (int i = 0; i < nb; i++) rev[8*(nb-1-i) +: 8] = v[8*i +: 8];
      v = rev;
    end
    case (kind)
      KIND_UNSIGNED: d.ival = v[INT_W-1:0];
      KIND_SIGNED: begin
        // Sign-extend from the top bit of the word as sized.
        if (v[nbits-1]) v = v | ~m;
        d.ival = v[INT_W-1:0];
      end
      KIND_FLOAT: begin
        case (nb)
          1: ebits = 4;
          2: ebits = 6;
          3: ebits = 8;
          4: ebits = 10;
          6: ebits = 12;
          default: ebits = 0;
        endcase
        if (ebits == 0) begin
          d.stat = 1'b1;
        end else begin
          fbits = nbits - 1 - ebits;
          bias = (1 << (ebits - 1)) - 1;
          efield = (v >> fbits) & ((64'd1 << ebits) - 64'd1);
          frac = v & ((64'd1 << fbits) - 64'd1);
          // Keep the top thirteen fraction bits; short fractions are padded below.
          if (fbits >= FRAC_W) f13 = FRAC_W'(frac >> (fbits - FRAC_W));
          else f13 = FRAC_W'(frac << (FRAC_W - fbits));
          d.sgn = v[nbits-1];
          if (efield == 0) begin
            // Denormal: no hidden one, smallest normal exponent.
            d.fsig = {1'b0, f13};
            d.fexp = EXP_W'(1 - bias);
          end else begin
            d.fsig = {1'b1, f13};
            d.fexp = EXP_W'(int'(efield) - bias);
          end
        end
      end
      default: d = '0;
    endcase
    return d;
  endfunction

  function automatic decoded_t int_res(input logic signed [INT_W-1:0] v);
    decoded_t d;
    d = '0;
    d.ival = v;
    return d;
  endfunction

  function automatic decoded_t flt_res(input logic s, input int e, input int sig);
    decoded_t d;
    d = '0;
    d.sgn = s;
    d.fexp = EXP_W'(e);
    d.fsig = SIG_W'(sig);
    return d;
  endfunction

  function automatic decoded_t err_res();
    decoded_t d;
    d = '0;
    d.stat = 1'b1;
    return d;
  endfunction

  function automatic logic [RAW_W-1:0] rand_word();
    logic [RAW_W-1:0] w;
    w = RAW_W'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = '1;
      // Whole bytes of zeros or ones make empty and saturated exponent fields common.
      2, 3: begin
        for (int i = 0; i < RAW_W / 8; i++) begin
          case ($urandom_range(0, 2))
            0: w[8*i +: 8] = 8'h00;
            1: w[8*i +: 8] = 8'hFF;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic add_row(input logic le, input kind_e_t kind, input logic [2:0] size,
                         input logic [RAW_W-1:0] word, input logic known, input decoded_t want);
    dir_row_t r;
    r.le = le;
    r.kind = kind;
    r.size = size;
    r.word = word;
    r.known = known;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  // Offers one item, idling at random first, and records what it must decode to once
  // the block takes it. Valid stays up afterwards so back-to-back items have no gap.
  task automatic offer_item(input logic [RAW_W-1:0] w, input logic known,
                            input decoded_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    raw_word <= w;
    do @(posedge clk); while (!in_ready);
    pending_decodes.push_back(known ? want : decode_word(w, le_cfg, kind_cfg, size_cfg));
  endtask

  // Stops offering and waits until the block has returned everything it owes.
  task automatic drain_pipe();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Registers only change with the pipeline empty, and only the ones that differ.
  task automatic set_config(input logic le, input kind_e_t kind, input logic [2:0] size);
    if (le == le_cfg && kind == kind_cfg && size == size_cfg) return;
    drain_pipe();
    if (le != le_cfg) write_reg(REG_LITTLE_ENDIAN, {2'b00, le});
    if (kind != kind_cfg) write_reg(REG_DATA_KIND, {1'b0, kind});
    if (size != size_cfg) write_reg(REG_SIZE_BYTES, size);
    le_cfg = le;
    kind_cfg = kind;
    size_cfg = size;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Receiver. It stalls at random, and on request holds off for a long stretch so the
  // pipeline fills and the block has to drop in_ready.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Every item leaving the block is compared with the oldest result still owed.
  always @(posedge clk) begin
    decoded_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_decodes.size() == 0) begin
        $display("%0t: unexpected result: int_value %0d, status %0d", $time, int_value, status);
        mismatches++;
      end else begin
        want = pending_decodes.pop_front();
        check_field("int_value", want.ival, int_value);
        check_field("float_sign", want.sgn, float_sign);
        check_field("float_exponent", want.fexp, float_exponent);
        check_field("float_significand", want.fsig, float_significand);
        check_field("status", want.stat, status);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic       le;
    kind_e_t    kind;
    logic [2:0] size;
    int         r;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items. The first runs on the reset setting: one unsigned byte, so the
    // high bytes of the word must be ignored.
    add_row(1'b0, KIND_UNSIGNED, 3'd1, 48'hFFFF_FFFF_FFA5, 1'b1, int_res(49'sd165));
    add_row(1'b0, KIND_SIGNED, 3'd1, 48'h0000_0000_0080, 1'b1, int_res(-49'sd128));
    add_row(1'b0, KIND_SIGNED, 3'd1, 48'h0000_0000_007F, 1'b1, int_res(49'sd127));
    add_row(1'b0, KIND_SIGNED, 3'd6, 48'h7FFF_FFFF_FFFF, 1'b1,
            int_res(49'sd140737488355327));
    add_row(1'b0, KIND_SIGNED, 3'd6, 48'h8000_0000_0000, 1'b1,
            int_res(-49'sd140737488355328));
    add_row(1'b0, KIND_UNSIGNED, 3'd6, 48'hFFFF_FFFF_FFFF, 1'b1,
            int_res(49'sd281474976710655));
    add_row(1'b0, KIND_UNSIGNED, 3'd6, 48'h0, 1'b1, int_res(49'sd0));
    // Byte reversal, within the sized word only.
    add_row(1'b1, KIND_UNSIGNED, 3'd6, 48'h0102_0304_0506, 1'b1,
            int_res(49'sh0605_0403_0201));
    add_row(1'b1, KIND_UNSIGNED, 3'd3, 48'hAB12_3456, 1'b1, int_res(49'sh56_3412));
    add_row(1'b1, KIND_SIGNED, 3'd2, 48'h0080, 1'b1, int_res(-49'sd32768));
    // Float formats: zero, one, denormals, all-ones exponent and both exponent extremes.
    add_row(1'b0, KIND_FLOAT, 3'd1, 48'h00, 1'b1, flt_res(1'b0, -6, 0));
    add_row(1'b0, KIND_FLOAT, 3'd1, 48'h38, 1'b1, flt_res(1'b0, 0, 'h2000));
    add_row(1'b0, KIND_FLOAT, 3'd1, 48'hFF, 1'b1, flt_res(1'b1, 8, 'h3C00));
    add_row(1'b0, KIND_FLOAT, 3'd2, 48'h3E00, 1'b1, flt_res(1'b0, 0, 'h2000));
    add_row(1'b0, KIND_FLOAT, 3'd2, 48'h81FF, 1'b0, '0);
    add_row(1'b0, KIND_FLOAT, 3'd3, 48'h3F_A5C3, 1'b0, '0);
    add_row(1'b1, KIND_FLOAT, 3'd4, 48'h1234_5678, 1'b0, '0);
    add_row(1'b0, KIND_FLOAT, 3'd6, 48'h7FFF_FFFF_FFFF, 1'b1, flt_res(1'b0, 2048, 'h3FFF));
    add_row(1'b0, KIND_FLOAT, 3'd6, 48'h8000_0000_0001, 1'b1, flt_res(1'b1, -2046, 0));
    add_row(1'b0, KIND_FLOAT, 3'd6, 48'h4ABC_DEF0_1234, 1'b0, '0);
    // A five-byte float has no format and only flags an error.
    add_row(1'b0, KIND_FLOAT, 3'd5, 48'h12_3456_789A, 1'b1, err_res());
    // Kind 3 is unused and yields an all-zero result.
    add_row(1'b0, KIND_UNUSED, 3'd3, 48'hDEAD_BEEF_CAFE, 1'b1, '0);
    // Size zero reads as one byte; sizes past six saturate.
    add_row(1'b0, KIND_UNSIGNED, 3'd0, 48'h1234, 1'b1, int_res(49'sh34));
    add_row(1'b0, KIND_UNSIGNED, 3'd7, 48'hFFFF_FFFF_FFFF, 1'b1,
            int_res(49'sd281474976710655));
    add_row(1'b0, KIND_FLOAT, 3'd7, 48'hC123_4567_89AB, 1'b0, '0);
    add_row(1'b1, KIND_FLOAT, 3'd0, 48'h9B, 1'b0, '0);

    foreach (dir_rows[i]) begin
      set_config(dir_rows[i].le, dir_rows[i].kind, dir_rows[i].size);
      offer_item(dir_rows[i].word, dir_rows[i].known, dir_rows[i].want);
    end

    // Random part: fourteen settings of fifty items each. The first four settings are
    // the extremes; later ones are drawn at random, now and then with an unused kind
    // or an out-of-range size.
    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: begin le = 1'b0; kind = KIND_SIGNED;   size = 3'd6; end
        1: begin le = 1'b1; kind = KIND_FLOAT;    size = 3'd1; end
        2: begin le = 1'b1; kind = KIND_FLOAT;    size = 3'd6; end
        3: begin le = 1'b0; kind = KIND_UNSIGNED; size = 3'd1; end
        default: begin
          le = 1'($urandom_range(0, 1));
          kind = ($urandom_range(0, 9) == 0) ? KIND_UNUSED : kind_e_t'(2'($urandom_range(0, 2)));
          r = $urandom_range(0, 15);
          size = (r == 0) ? 3'd0 : (r == 1) ? 3'd7 : 3'($urandom_range(1, 6));
        end
      endcase
      set_config(le, kind, size);
      // One whole setting runs with neither side idling.
      send_idle_pct = (ph == 3) ? 0 : 24;
      recv_idle_pct = (ph == 3) ? 0 : 24;
      for (int n = 0; n < 50; n++) begin
        // Long receiver stall while items keep coming, so the block backs up.
        if (ph == 5 && n == 10) hold_len = 60;
        // The sender pauses until every owed result is back.
        if (ph == 7 && n == 25) drain_pipe();
        offer_item(rand_word(), 1'b0, '0);
      end
    end

    drain_pipe();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_decodes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/mfid_pkg.sv
sv/mfid_align.sv
sv/mfid_field.sv
sv/mfid_out.sv
sv/minifloat_and_integer_decoder_core.sv
verif/tb_top.sv
